### rtl/core/assert_macros.svh
// Assertion macros shared by the serialiser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/coapser_pkg.sv
package coapser_pkg;

   localparam int unsigned QueueDepthDefault = 4;

   localparam logic [8:0] ExtBase       = 9'd13;
   localparam logic [8:0] ExtMax        = 9'd268;
   localparam logic [7:0] PayloadMarker = 8'hFF;

   localparam logic [3:0] MaxTokenReset   = 4'd8;
   localparam logic [8:0] MaxOptionReset  = 9'd24;
   localparam logic [9:0] MaxPayloadReset = 10'd64;

   typedef enum logic [2:0] {
      CMD_HEADER    = 3'd0,
      CMD_TOKEN     = 3'd1,
      CMD_OPT_HDR   = 3'd2,
      CMD_OPT_VALUE = 3'd3,
      CMD_PAYLOAD   = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ERR_OK          = 3'd0,
      ERR_TOKEN_LEN   = 3'd1,
      ERR_OPTION_LEN  = 3'd2,
      ERR_PAYLOAD_LEN = 3'd3,
      ERR_BAD_DELTA   = 3'd4
   } err_type;

   typedef enum logic [1:0] {
      CSR_MAX_TOKEN   = 2'd0,
      CSR_MAX_OPTION  = 2'd1,
      CSR_MAX_PAYLOAD = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [3:0] max_token;
      logic [8:0] max_option;
      logic [9:0] max_payload;
   } cfg_type;

   // One classified item: up to four message bytes, or one error word.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
      logic            byte_valid;
      err_type         error;
      logic            last_item;
   } job_type;

endpackage

### rtl/core/coapser_front.sv
module coapser_front
   import coapser_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [1:0]  req_msg_version,
   input  logic [1:0]  req_msg_type,
   input  logic [3:0]  req_token_length,
   input  logic [7:0]  req_msg_code,
   input  logic [15:0] req_message_id,
   input  logic [15:0] req_option_number,
   input  logic [9:0]  req_option_length,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_item,
   input  logic        queue_full,
   output logic        push,
   output job_type     job
);

   logic [15:0] running_ff, running_in;
   logic [9:0]  pcount_ff, pcount_in;
   logic        started_ff, started_in;

   logic        fire;
   logic [16:0] diff;
   logic        delta_bad;
   logic        len_bad;
   logic        dext, lext;
   logic [3:0]  dn, ln;
   logic [7:0]  dext_byte, lext_byte;

   assign req_stall = queue_full;
   assign fire      = req_valid && !req_stall;

   assign diff      = {1'b0, req_option_number} - {1'b0, running_ff};
   assign delta_bad = diff[16] || (diff[15:0] > {7'd0, ExtMax});
   assign len_bad   = (req_option_length > {1'b0, cfg.max_option})
                      || (req_option_length > {1'b0, ExtMax});
   assign dext      = diff[15:0] >= {7'd0, ExtBase};
   assign lext      = req_option_length >= {1'b0, ExtBase};
   assign dn        = dext ? ExtBase[3:0] : diff[3:0];
   assign ln        = lext ? ExtBase[3:0] : req_option_length[3:0];
   assign dext_byte = 8'(diff[8:0] - ExtBase);
   assign lext_byte = 8'(req_option_length[8:0] - ExtBase);

   always_comb begin
      job            = '0;
      job.error      = ERR_OK;
      job.byte_valid = 1'b1;
      job.last_item  = req_last_item;
      push           = 1'b0;
      running_in     = running_ff;
      pcount_in      = pcount_ff;
      started_in     = started_ff;
      case (cmd_type'(req_cmd))
         CMD_HEADER: begin
            push = fire;
            if (req_token_length > cfg.max_token) begin
               job.byte_valid = 1'b0;
               job.error      = ERR_TOKEN_LEN;
            end else begin
               job.bytes[0] = {req_msg_version, req_msg_type, req_token_length};
               job.bytes[1] = req_msg_code;
               job.bytes[2] = req_message_id[15:8];
               job.bytes[3] = req_message_id[7:0];
               job.last_idx = 2'd3;
               running_in   = '0;
               pcount_in    = '0;
               started_in   = 1'b0;
            end
         end
         CMD_TOKEN, CMD_OPT_VALUE: begin
            push         = fire;
            job.bytes[0] = req_data_byte;
         end
         CMD_OPT_HDR: begin
            push = fire;
            if (len_bad) begin
               job.byte_valid = 1'b0;
               job.error      = ERR_OPTION_LEN;
            end else if (delta_bad) begin
               job.byte_valid = 1'b0;
               job.error      = ERR_BAD_DELTA;
            end else begin
               job.bytes[0] = {dn, ln};
               // The delta extension comes before the length extension.
               job.bytes[1] = dext ? dext_byte : lext_byte;
               job.bytes[2] = lext_byte;
               job.last_idx = 2'({1'b0, dext} + {1'b0, lext});
               running_in   = req_option_number;
            end
         end
         CMD_PAYLOAD: begin
            push = fire;
            if (pcount_ff >= cfg.max_payload) begin
               job.byte_valid = 1'b0;
               job.error      = ERR_PAYLOAD_LEN;
            end else begin
               if (!started_ff) begin
                  job.bytes[0] = PayloadMarker;
                  job.bytes[1] = req_data_byte;
                  job.last_idx = 2'd1;
               end else begin
                  job.bytes[0] = req_data_byte;
               end
               started_in = 1'b1;
               pcount_in  = pcount_ff + 10'd1;
            end
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= '0;
         pcount_ff  <= '0;
         started_ff <= 1'b0;
      end else if (fire) begin
         running_ff <= running_in;
         pcount_ff  <= pcount_in;
         started_ff <= started_in;
      end
   end

endmodule

### rtl/core/coapser_queue.sv
`include "assert_macros.svh"

module coapser_queue
   import coapser_pkg::*;
#(
   parameter int unsigned Depth = QueueDepthDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type pop_job,
   output logic    full,
   output logic    empty
);

   localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntWidth = $clog2(Depth + 1);

   job_type               store_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;

   assign full    = count_ff == CntWidth'(Depth);
   assign empty   = count_ff == '0;
   assign pop_job = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_job;
      end
   end

   `ASSERT_SAME(no_push_full, clock, reset, push, !full, "push into a full queue")
   `ASSERT_SAME(no_pop_empty, clock, reset, pop, !empty, "pop from an empty queue")
   `ASSERT_NEXT(count_track, clock, reset, !reset,
      count_ff == CntWidth'($past(count_ff) + $past(push) - $past(pop)),
      "queue fill count lost track of pushes and pops")

endmodule

### rtl/core/coapser_back.sv
`include "assert_macros.svh"

module coapser_back
   import coapser_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       queue_empty,
   input  job_type    queue_job,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic [2:0] rsp_error_code,
   output logic       rsp_last_byte,
   output logic       rsp_message_end
);

   job_type    cur_ff, cur_in;
   logic [1:0] idx_ff, idx_in;
   logic       busy_ff, busy_in;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_bvalid_ff, out_bvalid_in;
   err_type    out_err_ff, out_err_in;
   logic       out_last_ff, out_last_in;
   logic       out_end_ff, out_end_in;

   logic advance;
   logic emit;
   logic job_done;

   // The output register frees up whenever the word in it is taken.
   assign advance  = !out_valid_ff || !rsp_stall;
   assign emit     = busy_ff && advance;
   assign job_done = idx_ff == cur_ff.last_idx;
   assign pop      = !queue_empty && (!busy_ff || (emit && job_done));

   always_comb begin
      cur_in        = cur_ff;
      idx_in        = idx_ff;
      busy_in       = busy_ff;
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_bvalid_in = out_bvalid_ff;
      out_err_in    = out_err_ff;
      out_last_in   = out_last_ff;
      out_end_in    = out_end_ff;
      if (advance) begin
         out_valid_in  = busy_ff;
         out_byte_in   = cur_ff.bytes[idx_ff];
         out_bvalid_in = cur_ff.byte_valid;
         out_err_in    = cur_ff.error;
         out_last_in   = job_done;
         out_end_in    = job_done && cur_ff.last_item;
      end
      if (emit) begin
         idx_in = idx_ff + 2'd1;
         if (job_done) begin
            busy_in = 1'b0;
         end
      end
      if (pop) begin
         cur_in  = queue_job;
         idx_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff        <= cur_in;
      out_byte_ff   <= out_byte_in;
      out_bvalid_ff <= out_bvalid_in;
      out_err_ff    <= out_err_in;
      out_last_ff   <= out_last_in;
      out_end_ff    <= out_end_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_byte_valid  = out_bvalid_ff;
   assign rsp_error_code  = out_err_ff;
   assign rsp_last_byte   = out_last_ff;
   assign rsp_message_end = out_end_ff;

   `ASSERT_SAME(err_word_shape, clock, reset, rsp_valid && !rsp_byte_valid,
      rsp_last_byte && (rsp_out_byte == 8'd0) && (rsp_error_code != ERR_OK),
      "an error word must be a lone zero word with a code")
   `ASSERT_SAME(ok_word_code, clock, reset, rsp_valid && rsp_byte_valid,
      rsp_error_code == ERR_OK, "a message byte carries an error code")
   `ASSERT_SAME(end_on_last, clock, reset, rsp_valid && rsp_message_end,
      rsp_last_byte, "message end away from the last word of an item")

endmodule

### rtl/core/coap_message_serializer.sv
// CoAP message serialiser. Items arrive on the req_ channel and the encoded message leaves
// one byte per word on the rsp_ channel. A front stage checks each item against the limit
// registers and the running option number and turns it into a short list of bytes, a small
// queue (four items by default) holds those lists, and a back stage sends one word per cycle
// through an output register while rsp_stall is low. An input item is taken every cycle while
// the queue has room; the output side sets the sustained rate: a header gives four words, an
// option header one to three, the first payload byte of a message two, every other item one,
// and an item that fails a check a single error word. Items with cmd 5 to 7 are taken and
// give no word. The limit registers may be written only while no item is in flight.
module coap_message_serializer
   import coapser_pkg::*;
#(
   parameter int unsigned QueueDepth = QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [1:0]  req_msg_version,
   input  logic [1:0]  req_msg_type,
   input  logic [3:0]  req_token_length,
   input  logic [7:0]  req_msg_code,
   input  logic [15:0] req_message_id,
   input  logic [15:0] req_option_number,
   input  logic [9:0]  req_option_length,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last_byte,
   output logic        rsp_message_end
);

   cfg_type cfg_ff, cfg_in;
   job_type push_job, pop_job;
   logic    push, pop, full, empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_MAX_TOKEN:   cfg_in.max_token   = csr_write_data[3:0];
            CSR_MAX_OPTION:  cfg_in.max_option  = csr_write_data[8:0];
            CSR_MAX_PAYLOAD: cfg_in.max_payload = csr_write_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_token   <= MaxTokenReset;
         cfg_ff.max_option  <= MaxOptionReset;
         cfg_ff.max_payload <= MaxPayloadReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   coapser_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_msg_version   (req_msg_version),
      .req_msg_type      (req_msg_type),
      .req_token_length  (req_token_length),
      .req_msg_code      (req_msg_code),
      .req_message_id    (req_message_id),
      .req_option_number (req_option_number),
      .req_option_length (req_option_length),
      .req_data_byte     (req_data_byte),
      .req_last_item     (req_last_item),
      .queue_full        (full),
      .push              (push),
      .job               (push_job)
   );

   coapser_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .full     (full),
      .empty    (empty)
   );

   coapser_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (empty),
      .queue_job       (pop_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_error_code  (rsp_error_code),
      .rsp_last_byte   (rsp_last_byte),
      .rsp_message_end (rsp_message_end)
   );

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
   import coapser_pkg::*;

   // Command codes that the block takes but ignores.
   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [1:0]  msg_version;
      logic [1:0]  msg_type;
      logic [3:0]  token_length;
      logic [7:0]  msg_code;
      logic [15:0] message_id;
      logic [15:0] option_number;
      logic [9:0]  option_length;
      logic [7:0]  data_byte;
      logic        last_item;
   } coap_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic [2:0] error_code;
      logic       last_byte;
      logic       message_end;
   } coap_word_type;

   typedef enum {STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY} stall_mode_type;

   class coap_byte_scoreboard;
      cfg_type       limits = '{MaxTokenReset, MaxOptionReset, MaxPayloadReset};
      logic [15:0]   running_opt = '0;
      logic [9:0]    payload_cnt = '0;
      logic          marker_sent = 1'b0;
      coap_word_type expected_words[$];
      coap_word_type item_words[$];
      int unsigned   fail_count = 0;

      function void apply_csr(csr_index_type idx, logic [9:0] value);
         case (idx)
            CSR_MAX_TOKEN:   limits.max_token = value[3:0];
            CSR_MAX_OPTION:  limits.max_option = value[8:0];
            CSR_MAX_PAYLOAD: limits.max_payload = value;
            default: ;
         endcase
      endfunction

      function void add_word(logic [7:0] data, logic valid, logic [2:0] err);
         coap_word_type w;
         w.out_byte = data;
         w.byte_valid = valid;
         w.error_code = err;
         w.last_byte = 1'b0;
         w.message_end = 1'b0;
         item_words.push_back(w);
      endfunction

      // Works out the words that one accepted item causes and queues them.
      function void note_item(coap_item_type it);
         logic [15:0] delta;
         logic [15:0] ext;
         logic [3:0]  dn;
         logic [3:0]  ln;
         item_words.delete();
         case (it.cmd)
            CMD_HEADER: begin
               if (it.token_length > limits.max_token) begin
                  add_word(8'h00, 1'b0, ERR_TOKEN_LEN);
               end else begin
                  add_word({it.msg_version, it.msg_type, it.token_length}, 1'b1, ERR_OK);
                  add_word(it.msg_code, 1'b1, ERR_OK);
                  add_word(it.message_id[15:8], 1'b1, ERR_OK);
                  add_word(it.message_id[7:0], 1'b1, ERR_OK);
                  running_opt = '0;
                  payload_cnt = '0;
                  marker_sent = 1'b0;
               end
            end
            CMD_TOKEN, CMD_OPT_VALUE: add_word(it.data_byte, 1'b1, ERR_OK);
            CMD_OPT_HDR: begin
               if (it.option_length > limits.max_option || it.option_length > ExtMax) begin
                  add_word(8'h00, 1'b0, ERR_OPTION_LEN);
               end else if (it.option_number < running_opt ||
                            (it.option_number - running_opt) > ExtMax) begin
                  add_word(8'h00, 1'b0, ERR_BAD_DELTA);
               end else begin
                  delta = it.option_number - running_opt;
                  dn = (delta < ExtBase) ? delta[3:0] : ExtBase[3:0];
                  ln = (it.option_length < ExtBase) ? it.option_length[3:0] : ExtBase[3:0];
                  add_word({dn, ln}, 1'b1, ERR_OK);
                  if (delta >= ExtBase) begin
                     ext = delta - 16'(ExtBase);
                     add_word(ext[7:0], 1'b1, ERR_OK);
                  end
                  if (it.option_length >= ExtBase) begin
                     ext = 16'(it.option_length) - 16'(ExtBase);
                     add_word(ext[7:0], 1'b1, ERR_OK);
                  end
                  running_opt = it.option_number;
               end
            end
            CMD_PAYLOAD: begin
               if (payload_cnt >= limits.max_payload) begin
                  add_word(8'h00, 1'b0, ERR_PAYLOAD_LEN);
               end else begin
                  if (!marker_sent) begin
                     add_word(PayloadMarker, 1'b1, ERR_OK);
                     marker_sent = 1'b1;
                  end
                  add_word(it.data_byte, 1'b1, ERR_OK);
                  payload_cnt = payload_cnt + 10'd1;
               end
            end
            default: ;
         endcase
         if (item_words.size() != 0) begin
            item_words[item_words.size() - 1].last_byte = 1'b1;
            item_words[item_words.size() - 1].message_end = it.last_item;
            foreach (item_words[i]) expected_words.push_back(item_words[i]);
         end
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
         end
      endfunction

      function void check_word(coap_word_type got);
         coap_word_type want;
         if (expected_words.size() == 0) begin
            $error("word with none expected: out_byte 0x%0h, error_code %0d",
                   got.out_byte, got.error_code);
            fail_count++;
            return;
         end
         want = expected_words.pop_front();
         compare_field("out_byte", want.out_byte, got.out_byte);
         compare_field("byte_valid", want.byte_valid, got.byte_valid);
         compare_field("error_code", want.error_code, got.error_code);
         compare_field("last_byte", want.last_byte, got.last_byte);
         compare_field("message_end", want.message_end, got.message_end);
      endfunction

      function int pending();
         return expected_words.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [9:0]  csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_cmd = '0;
   logic [1:0]  req_msg_version = '0;
   logic [1:0]  req_msg_type = '0;
   logic [3:0]  req_token_length = '0;
   logic [7:0]  req_msg_code = '0;
   logic [15:0] req_message_id = '0;
   logic [15:0] req_option_number = '0;
   logic [9:0]  req_option_length = '0;
   logic [7:0]  req_data_byte = '0;
   logic        req_last_item = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic [2:0]  rsp_error_code;
   logic        rsp_last_byte;
   logic        rsp_message_end;

   coap_byte_scoreboard sb = new;
   int             items_sent = 0;
   int             burst_left = 0;
   int             stall_left = 0;
   stall_mode_type stall_mode = STALL_NONE;

   coap_message_serializer u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_msg_version  (req_msg_version),
      .req_msg_type     (req_msg_type),
      .req_token_length (req_token_length),
      .req_msg_code     (req_msg_code),
      .req_message_id   (req_message_id),
      .req_option_number(req_option_number),
      .req_option_length(req_option_length),
      .req_data_byte    (req_data_byte),
      .req_last_item    (req_last_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_error_code   (rsp_error_code),
      .rsp_last_byte    (rsp_last_byte),
      .rsp_message_end  (rsp_message_end)
   );

   always #6 clock = ~clock;

   // The receiver picks a new stall pattern whenever its current run of random length ends.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(10, 60);
      end
      stall_left--;
      case (stall_mode)
         STALL_NONE:     rsp_stall = 1'b0;
         STALL_SPARSE:   rsp_stall = ($urandom_range(0, 3) == 0);
         STALL_PERIODIC: rsp_stall = ((stall_left % 5) < 2);
         default:        rsp_stall = ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         sb.note_item('{req_cmd, req_msg_version, req_msg_type, req_token_length,
                        req_msg_code, req_message_id, req_option_number,
                        req_option_length, req_data_byte, req_last_item});
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_word('{rsp_out_byte, rsp_byte_valid, rsp_error_code,
                         rsp_last_byte, rsp_message_end});
      end
   end

   function automatic coap_item_type random_item();
      coap_item_type it;
      it.cmd = 3'($urandom_range(0, 7));
      it.msg_version = 2'($urandom_range(0, 3));
      it.msg_type = 2'($urandom_range(0, 3));
      it.token_length = 4'($urandom_range(0, 15));
      it.msg_code = 8'($urandom_range(0, 255));
      it.message_id = 16'($urandom_range(0, 65535));
      it.option_number = 16'($urandom_range(0, 65535));
      it.option_length = 10'($urandom_range(0, 1023));
      it.data_byte = 8'($urandom_range(0, 255));
      it.last_item = 1'($urandom_range(0, 1));
      return it;
   endfunction

   function automatic coap_item_type make_header(logic [1:0] ver, logic [1:0] mtype,
                                                 logic [3:0] tkl, logic [7:0] code,
                                                 logic [15:0] mid, logic last);
      coap_item_type it;
      it = random_item();
      it.cmd = CMD_HEADER;
      it.msg_version = ver;
      it.msg_type = mtype;
      it.token_length = tkl;
      it.msg_code = code;
      it.message_id = mid;
      it.last_item = last;
      return it;
   endfunction

   function automatic coap_item_type make_byte(logic [2:0] cmd, logic [7:0] data, logic last);
      coap_item_type it;
      it = random_item();
      it.cmd = cmd;
      it.data_byte = data;
      it.last_item = last;
      return it;
   endfunction

   function automatic coap_item_type make_option(logic [15:0] num, logic [9:0] len,
                                                 logic last);
      coap_item_type it;
      it = random_item();
      it.cmd = CMD_OPT_HDR;
      it.option_number = num;
      it.option_length = len;
      it.last_item = last;
      return it;
   endfunction

   // Drives one item and holds it until it is taken; the sender pauses between bursts.
   task automatic send_item(input coap_item_type it);
      if (burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 10);
      end
      req_cmd = it.cmd;
      req_msg_version = it.msg_version;
      req_msg_type = it.msg_type;
      req_token_length = it.token_length;
      req_msg_code = it.msg_code;
      req_message_id = it.message_id;
      req_option_number = it.option_number;
      req_option_length = it.option_length;
      req_data_byte = it.data_byte;
      req_last_item = it.last_item;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      burst_left--;
      items_sent++;
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [9:0] value);
      csr_write_en = 1'b1;
      csr_index = idx;
      csr_write_data = value;
      sb.apply_csr(idx, value);
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   // Limits may only change once every word is out and the pipeline has emptied,
   // since ignored commands leave nothing to wait for.
   task automatic set_limits(input int tok, input int opt, input int pay);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
      write_csr(CSR_MAX_TOKEN, 10'(tok));
      write_csr(CSR_MAX_OPTION, 10'(opt));
      write_csr(CSR_MAX_PAYLOAD, 10'(pay));
   endtask

   // A mostly well-formed message with random content, now and then without its
   // header, broken by stray items or with fields beyond the limits.
   task automatic send_random_message();
      coap_item_type msg[$];
      int run;
      int onum;
      int olen;
      int lim;
      int r;
      int n_tok;
      run = int'(sb.running_opt);
      if ($urandom_range(0, 9) != 0) begin
         n_tok = ($urandom_range(0, 99) < 85) ? $urandom_range(0, sb.limits.max_token)
                                              : $urandom_range(0, 15);
         msg.push_back(make_header(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                                   4'(n_tok), 8'($urandom_range(0, 255)),
                                   16'($urandom_range(0, 65535)), 1'b0));
         if (n_tok <= sb.limits.max_token) run = 0;
         repeat (n_tok)
            msg.push_back(make_byte(CMD_TOKEN, 8'($urandom_range(0, 255)), 1'b0));
      end
      repeat ($urandom_range(0, 4)) begin
         r = $urandom_range(0, 99);
         if (r < 55) onum = run + $urandom_range(0, ExtBase - 1);
         else if (r < 80) onum = run + $urandom_range(ExtBase, ExtMax);
         else if (r < 90) onum = run + $urandom_range(ExtMax + 1, 4000);
         else if (r < 95 && run > 0) onum = run - $urandom_range(1, run);
         else onum = $urandom_range(0, 65535);
         onum = onum % 65536;
         lim = int'(sb.limits.max_option);
         r = $urandom_range(0, 99);
         if (r < 70) olen = $urandom_range(0, (lim < 12) ? lim : 12);
         else if (r < 85) olen = $urandom_range(0, lim);
         else olen = $urandom_range(lim + 1, 1023);
         msg.push_back(make_option(16'(onum), 10'(olen), 1'b0));
         if (olen <= lim && olen <= ExtMax && onum >= run && onum - run <= ExtMax) run = onum;
         repeat ((olen <= 8) ? olen : $urandom_range(0, 8))
            msg.push_back(make_byte(CMD_OPT_VALUE, 8'($urandom_range(0, 255)), 1'b0));
      end
      repeat (($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10))
         msg.push_back(make_byte(CMD_PAYLOAD, 8'($urandom_range(0, 255)), 1'b0));
      if (msg.size() == 0) msg.push_back(random_item());
      msg[msg.size() - 1].last_item = 1'b1;
      foreach (msg[i]) begin
         if ($urandom_range(0, 14) == 0) send_item(random_item());
         send_item(msg[i]);
      end
   endtask

   initial begin
      coap_item_type it;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // Directed part under the reset limits: token 8, option 24, payload 64.
      send_item(make_header(2'd3, 2'd3, 4'd8, 8'hFF, 16'hFFFF, 1'b0));
      send_item(make_byte(CMD_TOKEN, 8'h00, 1'b0));
      send_item(make_byte(CMD_TOKEN, 8'hFF, 1'b0));
      send_item(make_option(16'd0, 10'd0, 1'b0));
      send_item(make_option(16'd12, 10'd12, 1'b0));
      send_item(make_option(16'd25, 10'd13, 1'b0));
      send_item(make_option(16'd24, 10'd0, 1'b0));
      send_item(make_option(16'd294, 10'd0, 1'b0));
      send_item(make_option(16'd293, 10'd24, 1'b0));
      send_item(make_option(16'd293, 10'd25, 1'b0));
      send_item(make_byte(CMD_OPT_VALUE, 8'hA5, 1'b0));
      send_item(make_byte(CMD_PAYLOAD, 8'h00, 1'b0));
      send_item(make_byte(CMD_PAYLOAD, 8'hFF, 1'b1));
      send_item(make_header(2'd1, 2'd0, 4'd9, 8'h01, 16'h1234, 1'b0));
      send_item(make_header(2'd1, 2'd2, 4'd15, 8'h45, 16'h8001, 1'b1));
      send_item(make_header(2'd0, 2'd0, 4'd0, 8'h00, 16'h0000, 1'b1));
      it = random_item();
      it.cmd = CMD_SPARE_LO;
      send_item(it);
      it = random_item();
      it.cmd = CMD_SPARE_HI;
      send_item(it);
      send_item(make_option(16'hFFFF, 10'd1023, 1'b0));
      send_item(make_option(16'hFFFF, 10'd0, 1'b1));

      // Tightest token and payload limits, widest option limit.
      set_limits(0, int'(ExtMax), 0);
      send_item(make_header(2'd1, 2'd1, 4'd1, 8'h02, 16'h00FF, 1'b0));
      send_item(make_header(2'd1, 2'd2, 4'd0, 8'h44, 16'hFF00, 1'b0));
      send_item(make_byte(CMD_PAYLOAD, 8'h5A, 1'b0));
      send_item(make_option(16'(ExtMax), 10'(ExtMax), 1'b0));
      send_item(make_option(16'(ExtMax), 10'(ExtMax) + 10'd1, 1'b1));

      set_limits(8, int'(ExtMax), 1023);
      while (items_sent < 80) send_random_message();
      set_limits(0, 0, 0);
      while (items_sent < 120) send_random_message();
      set_limits($urandom_range(0, 8), $urandom_range(0, ExtMax), $urandom_range(0, 16));
      while (items_sent < 180) send_random_message();
      set_limits(4, 40, 3);
      while (items_sent < 230) send_random_message();

      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (sb.fail_count == 0 && sb.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
